// ===== hw/rtl/bsm_pkg.sv =====
// ----------------------------------------------------------------------------
// bsm_pkg: shared types and constants of the byte stack machine core
// Mode codes, field widths and the default global array size.
// ----------------------------------------------------------------------------
`default_nettype none
package bsm_pkg;
    localparam int GlobalBytesDef = 1024;
    localparam int ModeW  = 4;
    localparam int ByteW  = 8;
    localparam int ImmW   = 32;
    localparam int GaddrW = 16;
    localparam int InDataW  = 64;   // 4+8+32+16 = 60, padded to 64
    localparam int OutDataW = 24;   // 1+8+8 = 17, padded to 24

    typedef enum logic [ModeW-1:0] {
        M_NOP     = 4'd0,
        M_PUSHV   = 4'd1,
        M_PUSHZ   = 4'd2,
        M_PUSHB   = 4'd3,
        M_SEXT    = 4'd4,
        M_DUP     = 4'd5,
        M_DUPW    = 4'd6,
        M_GETG    = 4'd7,
        M_GETGC   = 4'd8,
        M_SETG    = 4'd9,
        M_SETGC   = 4'd10,
        M_POP     = 4'd11,
        M_INC     = 4'd12,
        M_DEC     = 4'd13,
        M_ILLEGAL = 4'd14,
        M_UNUSED  = 4'd15
    } t_mode;
endpackage
`default_nettype wire

// ===== hw/rtl/byte_stack_machine_core_top.sv =====
// ----------------------------------------------------------------------------
// byte_stack_machine_core_top: byte stack machine instruction executor
// Runs one pre-decoded instruction per input word against a 256-byte stack
// and a global byte array, returning status, top byte and depth.
// ----------------------------------------------------------------------------
// Each op reads the stack (S_RD, S_RDW), is decided in S_DECIDE, then reads
//   the top byte (S_TOPRD, S_TOPW) and sends it from S_DONE; byte loops pass
//   their loop and write states per byte (plus S_GRD for global reads), counted
//   ops rerun S_DECIDE with the popped count. One word at a time: s_axis_tready
//   is high only in idle. A result waiting in the output register holds the next op at its end.
// Reset (i_rst_n low, synchronous): pointer to 0, then a sweep clears the stack
//   and global memories (max(GLOBAL_BYTES, 256) entries, no input accepted).
`default_nettype none
module byte_stack_machine_core_top
    import bsm_pkg::*;
#(
    parameter int GLOBAL_BYTES = GlobalBytesDef
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    // tdata: mode[3:0], count[11:4], immediate[43:12], global_address[59:44]
    input  wire logic [InDataW-1:0]  s_axis_tdata,
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    // tdata: status[0], top_byte[8:1], depth[16:9]
    output logic [OutDataW-1:0]      m_axis_tdata
);
    localparam int GAW = $clog2(GLOBAL_BYTES);
    localparam int CW  = (GAW > 8) ? GAW : 8;   // clear sweep counter
    // reciprocal for the global address reduction: q = (a * Recip) >> 32
    // lands on floor(a / GLOBAL_BYTES) or one below it
    localparam logic [28:0] Recip = 29'((64'd1 << 32) / GLOBAL_BYTES);
    localparam logic [15:0] MLow  = 16'(GLOBAL_BYTES);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RD, S_RDW, S_DECIDE, S_LOOP, S_GRD, S_LOOPW, S_SET,
        S_SETW, S_RMW, S_TOPRD, S_TOPW, S_DONE
    } t_state;

    t_state               r_state;
    logic [CW:0]          r_clr;
    logic [7:0]           r_sp;
    t_mode                r_mode;
    logic [7:0]           r_n, r_i, r_fill;
    logic [ImmW-1:0]      r_imm;
    logic [GaddrW-1:0]    r_base;
    logic                 r_err, r_phase;
    logic                 r_ovalid;
    logic [OutDataW-1:0]  r_odata;
    logic [GaddrW-1:0]    r_gaddr;
    logic [15:0]          r_q;

    logic [7:0] stk [256];
    logic [7:0] glb [GLOBAL_BYTES];
    logic [7:0] r_srd, r_grd;

    // memory ports
    logic       s_we, g_we;
    logic [7:0] s_wa, s_wd, s_ra;
    logic [GAW-1:0] g_wa, g_ra;
    logic [7:0] g_wd;

    always_ff @(posedge i_clk) begin
        if (s_we) stk[s_wa] <= s_wd;
        r_srd <= stk[s_ra];
    end
    always_ff @(posedge i_clk) begin
        if (g_we) glb[g_wa] <= g_wd;
        r_grd <= glb[g_ra];
    end

    // shared adder: forms the 16-bit global address for the get and set loops
    logic [GaddrW-1:0] gsum;
    logic [7:0] room_lim;
    logic in_acc;

    // address reduction, two stages: quotient estimate registered with the
    // address, then remainder with one correcting subtract
    logic [44:0]    q_prod;
    logic [15:0]    g_diff, g_fix;
    logic [GAW-1:0] g_rem;

    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign room_lim = 8'(9'd256 - {1'b0, r_n});

    always_comb begin
        q_prod = {29'd0, gsum} * {16'd0, Recip};
        g_diff = r_gaddr - r_q * MLow;
        g_fix  = g_diff - MLow;
        g_rem  = ({1'b0, g_diff} >= 17'(GLOBAL_BYTES)) ? g_fix[GAW-1:0] : g_diff[GAW-1:0];
    end

    always_ff @(posedge i_clk) begin
        r_gaddr <= gsum;
        r_q     <= {3'd0, q_prod[44:32]};
    end

    always_comb begin
        s_we = 1'b0; s_wa = r_sp; s_wd = 8'd0; s_ra = r_sp - 8'd1;
        g_we = 1'b0; g_wa = '0; g_wd = r_srd; g_ra = '0;
        gsum = r_base + GaddrW'(r_i);
        case (r_state)
            S_CLEAR: begin
                s_we = 1'b1; s_wa = r_clr[7:0];
                g_we = 1'b1; g_wa = r_clr[GAW-1:0]; g_wd = 8'd0;
            end
            S_RD, S_RDW: begin
                case (r_mode)
                    M_DUP:   s_ra = r_sp - r_n;
                    M_DUPW:  s_ra = r_sp - r_n - 8'd1;
                    default: s_ra = r_sp - 8'd1;
                endcase
            end
            S_LOOP: begin
                gsum = r_base + GaddrW'(r_n) - GaddrW'(1) - GaddrW'(r_i);
                s_ra = r_sp - 8'd1;
            end
            S_GRD: g_ra = g_rem;
            S_LOOPW: begin
                s_we = 1'b1;
                case (r_mode)
                    M_PUSHB: s_wd = (r_i < 8'd4) ? r_imm[8*r_i[1:0] +: 8] : 8'd0;
                    M_GETG, M_GETGC: s_wd = r_grd;
                    default: s_wd = r_fill;
                endcase
            end
            S_SETW: begin
                g_we = 1'b1; g_wa = g_rem; g_wd = r_srd;
            end
            S_RMW: begin
                s_we = 1'b1; s_wa = r_sp - 8'd1;
                s_wd = (r_mode == M_INC) ? r_srd + 8'd1 : r_srd - 8'd1;
            end
            S_DECIDE: begin
                if (r_mode == M_DUP || r_mode == M_DUPW) begin
                    s_we = (r_mode == M_DUP) ? (r_sp != 8'd255)
                                             : (r_phase || r_sp < 8'd254);
                    s_wd = r_srd;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR; r_clr <= '0; r_sp <= 8'd0; r_ovalid <= 1'b0;
            r_phase <= 1'b0; r_err <= 1'b0;
        end else begin
            if (r_ovalid && m_axis_tready) r_ovalid <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == (CW+1)'(((GLOBAL_BYTES > 256) ? GLOBAL_BYTES : 256) - 1))
                        r_state <= S_IDLE;
                end
                S_IDLE: if (in_acc) begin
                    r_mode <= t_mode'(s_axis_tdata[3:0]);
                    r_n    <= s_axis_tdata[11:4];
                    r_imm  <= s_axis_tdata[43:12];
                    r_base <= s_axis_tdata[59:44];
                    r_i <= 8'd0; r_err <= 1'b0; r_phase <= 1'b0;
                    r_state <= S_RD;
                end
                S_RD: r_state <= S_RDW;
                S_RDW: r_state <= S_DECIDE;
                S_DECIDE: begin
                    r_state <= S_TOPRD;
                    case (r_mode)
                        M_NOP: ;
                        M_PUSHV: begin
                            r_fill <= r_imm[7:0];
                            r_n <= 8'd1;
                            if (r_sp == 8'd255) r_err <= 1'b1;
                            else r_state <= S_LOOPW;
                        end
                        M_PUSHZ: begin
                            r_fill <= 8'd0;
                            if (r_n != 8'd0) r_state <= S_LOOP;
                        end
                        M_PUSHB, M_SEXT, M_GETG: begin
                            r_fill <= r_srd[7] ? 8'hff : 8'h00;
                            if (r_sp < room_lim) r_state <= S_LOOP;
                            else r_err <= 1'b1;
                        end
                        M_GETGC: begin
                            r_n <= r_srd; r_sp <= r_sp - 8'd1;
                            r_mode <= M_GETG; r_state <= S_DECIDE;
                            // re-run check with popped count
                        end
                        M_SETGC: begin
                            r_n <= r_srd; r_sp <= r_sp - 8'd1;
                            r_mode <= M_SETG; r_state <= S_DECIDE;
                        end
                        M_SETG: if (r_n != 8'd0) r_state <= S_SET;
                        M_DUP: begin
                            if (r_sp == 8'd255) r_err <= 1'b1;
                            else r_sp <= r_sp + 8'd1;
                        end
                        M_DUPW: begin
                            if (r_phase == 1'b0 && r_sp >= 8'd254) begin
                                r_err <= 1'b1;
                            end else begin
                                r_sp <= r_sp + 8'd1;
                                if (r_phase == 1'b0) begin
                                    r_phase <= 1'b1; r_state <= S_RD;
                                end
                            end
                        end
                        M_POP: r_sp <= r_sp - r_n;
                        M_INC, M_DEC: r_state <= S_RMW;
                        default: r_err <= 1'b1;
                    endcase
                end
                S_LOOP: begin
                    if (r_mode == M_PUSHZ && r_sp == 8'd255) r_state <= S_TOPRD;
                    else if (r_mode == M_GETG) r_state <= S_GRD;
                    else r_state <= S_LOOPW;
                end
                S_GRD: r_state <= S_LOOPW;
                S_LOOPW: begin
                    r_sp <= r_sp + 8'd1;
                    r_i  <= r_i + 8'd1;
                    r_state <= (r_i + 8'd1 == r_n) ? S_TOPRD : S_LOOP;
                end
                S_SET: begin
                    r_sp <= r_sp - 8'd1;
                    r_state <= S_SETW;
                end
                S_SETW: begin
                    r_i <= r_i + 8'd1;
                    r_state <= (r_i + 8'd1 == r_n) ? S_TOPRD : S_SET;
                end
                S_RMW: r_state <= S_TOPRD;
                S_TOPRD: r_state <= S_TOPW;
                S_TOPW: r_state <= S_DONE;
                S_DONE: if (!r_ovalid) begin
                    r_odata <= {7'd0, r_sp, r_srd, r_err};
                    r_ovalid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
            // push-zeros overflow flag
            if (r_state == S_LOOP && r_mode == M_PUSHZ && r_sp == 8'd255) r_err <= 1'b1;
        end
    end

    // pop in S_SET: read address must follow the decrement
    // (stack read in S_SET uses s_ra = r_sp-1, data lands by S_SETW)

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> r_state == S_IDLE) else $error("ready outside idle");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !m_axis_tready) |=> $stable(r_odata)) else $error("out changed");
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !m_axis_tready) |=> r_ovalid) else $error("out dropped");
endmodule
`default_nettype wire

// ===== sim/bsm_checker.sv =====
// ----------------------------------------------------------------------------
// bsm_checker: result predictor and scoreboard for the byte stack machine
// Watches both stream channels, runs each accepted instruction word through
// its own copy of the stack and global memory, and compares every result
// word against the oldest prediction, reporting each field on a mismatch.
// ----------------------------------------------------------------------------
`default_nettype none
module bsm_checker
    import bsm_pkg::*;
#(
    parameter int GLOBAL_BYTES = GlobalBytesDef
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire logic                i_in_ready,
    input  wire logic [InDataW-1:0]  i_in_data,
    input  wire logic                i_out_valid,
    input  wire logic                i_out_ready,
    input  wire logic [OutDataW-1:0] i_out_data,
    output int                       o_errors,
    output int                       o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic       status;
        logic [7:0] top_byte;
        logic [7:0] depth;
    } t_result;

    logic [7:0] sp;
    logic [7:0] stk [256];
    logic [7:0] glb [GLOBAL_BYTES];
    t_result    expected_results[$];

    function automatic int gidx(int a);
        return (a & 16'hffff) % GLOBAL_BYTES;
    endfunction

    function automatic bit has_room(int n);
        return int'(sp) < ((256 - n) & 8'hff);
    endfunction

    function automatic bit push_byte(logic [7:0] v);
        if (sp == 8'd255) return 1'b1;
        stk[sp] = v;
        sp = sp + 8'd1;
        return 1'b0;
    endfunction

    function automatic logic [7:0] pop_byte();
        sp = sp - 8'd1;
        return stk[sp];
    endfunction

    function automatic bit load_globals(int gbase, int n);
        bit dummy;
        if (!has_room(n)) return 1'b1;
        for (int i = 0; i < n; i++) dummy = push_byte(glb[gidx(gbase + n - 1 - i)]);
        return 1'b0;
    endfunction

    function automatic void store_globals(int gbase, int n);
        for (int i = 0; i < n; i++) glb[gidx(gbase + i)] = pop_byte();
    endfunction

    function automatic t_result execute(logic [InDataW-1:0] w);
        t_mode       op;
        int          n;
        logic [31:0] imm;
        int          gbase;
        bit          err;
        bit          dummy;
        logic [7:0]  fill;
        t_result     r;
        op    = t_mode'(w[3:0]);
        n     = int'(w[11:4]);
        imm   = w[43:12];
        gbase = int'(w[59:44]);
        err   = 1'b0;
        case (op)
            M_NOP: ;
            M_PUSHV: err = push_byte(imm[7:0]);
            M_PUSHZ: begin
                for (int i = 0; i < n && !err; i++) err = push_byte(8'h00);
            end
            M_PUSHB: begin
                if (!has_room(n)) err = 1'b1;
                else for (int i = 0; i < n; i++)
                    dummy = push_byte(i < 4 ? imm[8*i +: 8] : 8'h00);
            end
            M_SEXT: begin
                if (!has_room(n)) err = 1'b1;
                else begin
                    fill = stk[sp - 8'd1][7] ? 8'hff : 8'h00;
                    for (int i = 0; i < n; i++) dummy = push_byte(fill);
                end
            end
            M_DUP: err = push_byte(stk[sp - 8'(n)]);
            M_DUPW: begin
                if (!has_room(2)) err = 1'b1;
                else begin
                    dummy = push_byte(stk[sp - 8'(n + 1)]);
                    dummy = push_byte(stk[sp - 8'(n + 1)]);
                end
            end
            M_GETG:  err = load_globals(gbase, n);
            M_GETGC: err = load_globals(gbase, int'(pop_byte()));
            M_SETG:  store_globals(gbase, n);
            M_SETGC: store_globals(gbase, int'(pop_byte()));
            M_POP:   sp = sp - 8'(n);
            M_INC:   stk[sp - 8'd1] = stk[sp - 8'd1] + 8'd1;
            M_DEC:   stk[sp - 8'd1] = stk[sp - 8'd1] - 8'd1;
            default: err = 1'b1;
        endcase
        r.status   = err;
        r.top_byte = stk[sp - 8'd1];
        r.depth    = sp;
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        t_result got;
        t_result exp_r;
        if (!i_rst_n) begin
            sp = 8'd0;
            foreach (stk[i]) stk[i] = 8'h00;
            foreach (glb[i]) glb[i] = 8'h00;
            expected_results.delete();
            o_errors <= 0;
            o_pending <= 0;
        end else begin
            if (i_in_valid && i_in_ready) expected_results.push_back(execute(i_in_data));
            if (i_out_valid && i_out_ready) begin
                got = t_result'({i_out_data[0], i_out_data[8:1], i_out_data[16:9]});
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result word %h", $time, i_out_data);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (got !== exp_r) begin
                        $display("%0t: mismatch status exp %0d got %0d, top exp %h got %h, depth exp %0d got %0d",
                                 $time, exp_r.status, got.status, exp_r.top_byte, got.top_byte,
                                 exp_r.depth, got.depth);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            o_pending <= expected_results.size();
        end
    end
endmodule
`default_nettype wire

// ===== sim/tb_byte_stack_machine_core_top.sv =====
// ----------------------------------------------------------------------------
// tb_byte_stack_machine_core_top: stimulus and verdict for the stack machine
// Drives directed corner instructions, then random mixes biased toward
// pushes and global traffic, with bursty input and random output stalls.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_byte_stack_machine_core_top;
    import bsm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NumRandom = 650;
    localparam longint CycleLimit = 5000000;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    // tdata: mode[3:0], count[11:4], immediate[43:12], global_address[59:44]
    logic [InDataW-1:0]  s_axis_tdata = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    // tdata: status[0], top_byte[8:1], depth[16:9]
    logic [OutDataW-1:0] m_axis_tdata;
    int                  errors;
    int                  pending;
    longint              cycles = 0;
    bit                  stall_on = 1'b1;

    always #10 i_clk = ~i_clk;

    byte_stack_machine_core_top dut (.*);

    bsm_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .i_in_ready(s_axis_tready), .i_in_data(s_axis_tdata),
        .i_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready), .i_out_data(m_axis_tdata),
        .o_errors(errors), .o_pending(pending)
    );

    // Watchdog: covers the clear sweep and worst-case per-byte ops with stalls.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Receiver: stalls in phases; sometimes always ready, sometimes choppy.
    always @(posedge i_clk) begin
        if (($urandom & 63) == 0) stall_on <= ~stall_on;
        m_axis_tready <= stall_on ? ($urandom_range(0, 3) != 0) : 1'b1;
    end

    int gap_left = 0;

    // Send one word; valid stays high until accepted and drops only for gaps.
    task automatic send_word(t_mode op, logic [7:0] n, logic [31:0] imm, logic [15:0] ga);
        if (gap_left > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap_left) @(posedge i_clk);
            gap_left = 0;
        end else if (($urandom & 7) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'h0, ga, imm, n, op};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic random_word();
        int pick;
        t_mode op;
        logic [7:0] n;
        pick = $urandom_range(0, 99);
        n = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 5));
        if (pick < 20)      op = M_PUSHV;
        else if (pick < 28) op = M_PUSHB;
        else if (pick < 33) op = M_PUSHZ;
        else if (pick < 38) op = M_SEXT;
        else if (pick < 45) op = M_DUP;
        else if (pick < 50) op = M_DUPW;
        else if (pick < 58) op = M_GETG;
        else if (pick < 62) op = M_GETGC;
        else if (pick < 72) op = M_SETG;
        else if (pick < 76) op = M_SETGC;
        else if (pick < 82) op = M_POP;
        else if (pick < 88) op = M_INC;
        else if (pick < 93) op = M_DEC;
        else                op = t_mode'($urandom_range(0, 15));
        // keep global addresses mostly in a small window so reads hit written bytes
        send_word(op, n, $urandom,
                  ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 31)));
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed corners
        send_word(M_NOP, 8'd0, 32'h0, 16'h0);
        send_word(M_PUSHV, 8'hff, 32'hffff_ff80, 16'hffff);
        send_word(M_SEXT, 8'd3, 32'h0, 16'h0);
        send_word(M_SEXT, 8'd0, 32'h0, 16'h0);
        send_word(M_PUSHB, 8'd0, 32'h1234_5678, 16'h0);
        send_word(M_PUSHB, 8'd6, 32'hdead_beef, 16'h0);
        send_word(M_DUP, 8'd0, 32'h0, 16'h0);
        send_word(M_DUP, 8'd3, 32'h0, 16'h0);
        send_word(M_DUPW, 8'd1, 32'h0, 16'h0);
        send_word(M_SETG, 8'd4, 32'h0, 16'hffff);
        send_word(M_GETG, 8'd4, 32'h0, 16'hfffe);
        send_word(M_GETG, 8'd0, 32'h0, 16'h0);
        send_word(M_PUSHV, 8'd0, 32'h2, 16'h0);
        send_word(M_GETGC, 8'd0, 32'h0, 16'h3ff);
        send_word(M_PUSHV, 8'd0, 32'h2, 16'h0);
        send_word(M_SETGC, 8'd0, 32'h0, 16'h10);
        send_word(M_INC, 8'd0, 32'h0, 16'h0);
        send_word(M_DEC, 8'd0, 32'h0, 16'h0);
        send_word(M_ILLEGAL, 8'd0, 32'h0, 16'h0);
        send_word(M_UNUSED, 8'd0, 32'h0, 16'h0);
        send_word(M_PUSHZ, 8'd255, 32'h0, 16'h0);   // overflows at 255, keeps zeros
        send_word(M_PUSHV, 8'd0, 32'h55, 16'h0);    // single push fails when full
        send_word(M_DUPW, 8'd0, 32'h0, 16'h0);
        send_word(M_POP, 8'd255, 32'h0, 16'h0);
        send_word(M_SETG, 8'd3, 32'h0, 16'h0);      // pointer wraps below zero
        s_axis_tvalid <= 1'b0;

        // hold off until everything is drained once
        do @(posedge i_clk); while (pending != 0);

        for (int k = 0; k < NumRandom; k++) begin
            if (($urandom & 15) == 0) gap_left = $urandom_range(1, 20);
            random_word();
        end
        s_axis_tvalid <= 1'b0;

        do @(posedge i_clk); while (pending != 0);
        repeat (600) @(posedge i_clk);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
`default_nettype wire
